FILE: rtl/core/efg_pkg.sv
// Shared definitions for the event flag group: field widths, request and
// status codes, and the packed layout of one queued waiter.
// No dependencies.
package efg_pkg;

    localparam int FLAG_W = 32;
    localparam int TASK_W = 8;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] FN_POLL   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WAIT   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CANCEL = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd6;
    localparam logic [FUNC_W-1:0] FN_CREATE = 3'd7;

    localparam logic [STAT_W-1:0] STS_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STS_NOT_MET   = 3'd1;
    localparam logic [STAT_W-1:0] STS_QUEUED    = 3'd2;
    localparam logic [STAT_W-1:0] STS_BAD_PARAM = 3'd3;
    localparam logic [STAT_W-1:0] STS_FULL      = 3'd4;
    localparam logic [STAT_W-1:0] STS_DELETED   = 3'd5;
    localparam logic [STAT_W-1:0] STS_INVALID   = 3'd6;
    localparam logic [STAT_W-1:0] STS_NOT_FOUND = 3'd7;

    typedef struct packed {
        logic [TASK_W-1:0] tid;
        logic [FLAG_W-1:0] pattern;
        logic              need_all;
        logic              auto_clear;
    } t_waiter;

endpackage

FILE: rtl/core/efg_req_if.sv
// Request channel of the event flag group: valid/ready plus one request.
// Depends on efg_pkg.
interface efg_req_if import efg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
    logic [FLAG_W-1:0] flag_bits;
    logic              need_all;
    logic              auto_clear;

    modport source (output valid, func, task_id, flag_bits, need_all, auto_clear,
                    input ready);
    modport sink (input valid, func, task_id, flag_bits, need_all, auto_clear,
                  output ready);
endinterface

FILE: rtl/core/efg_rsp_if.sv
// Result channel of the event flag group: valid/ready plus one result.
// Depends on efg_pkg.
interface efg_rsp_if import efg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TASK_W-1:0] target_task;
    logic [STAT_W-1:0] status;
    logic [FLAG_W-1:0] flags_seen;
    logic              last;

    modport source (output valid, kind, target_task, status, flags_seen, last,
                    input ready);
    modport sink (input valid, kind, target_task, status, flags_seen, last,
                  output ready);
endinterface

FILE: rtl/core/efg_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module efg_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/event_flag_group_with_waiters_unit.sv
// Event flag group with an ordered queue of blocked waiters.
// Depends on efg_pkg, efg_req_if, efg_rsp_if and efg_ram.
//
// One request is taken at a time. A request that needs no queue walk goes
// through capture, execute and reply before its reply is offered. Set (when
// it adds bits), toggle, cancel and delete walk the waiter queue through a
// single RAM read port, one waiter per cycle unless the result channel
// stalls a release, before their reply. Releases come out in queue order
// and are followed in the same transaction stream by the final reply, which
// carries last.
module event_flag_group_with_waiters_unit import efg_pkg::*; #(
    parameter int WAITER_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efg_req_if.sink     i_req,
    efg_rsp_if.source   o_rsp
);

    localparam int AW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CW = $clog2(WAITER_SLOTS + 1);
    localparam int WW = $bits(t_waiter);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_REPLY = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [TASK_W-1:0] r_tid, n_tid;
    logic [FLAG_W-1:0] r_pat, n_pat;
    logic              r_all, n_all;
    logic              r_clr, n_clr;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              r_alive, n_alive;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_keep, n_keep;
    logic              r_found, n_found;
    logic [STAT_W-1:0] r_rep_status, n_rep_status;
    logic [FLAG_W-1:0] r_rep_seen, n_rep_seen;

    logic              r_o_valid, n_o_valid;
    logic              r_o_kind, n_o_kind;
    logic [TASK_W-1:0] r_o_task, n_o_task;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [FLAG_W-1:0] r_o_seen, n_o_seen;
    logic              r_o_last, n_o_last;

    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [AW-1:0] s_raddr;
    t_waiter       s_wdata;
    logic [WW-1:0] s_rdata;
    t_waiter       s_rd;
    logic          s_out_free;
    logic [FLAG_W-1:0] s_hit;
    logic          s_met;
    logic [FLAG_W-1:0] s_whit;
    logic          s_wmet;
    logic          s_release;
    logic [CW-1:0] s_idx_inc;

    efg_ram #(
        .WIDTH (WW),
        .DEPTH (WAITER_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign s_rd       = t_waiter'(s_rdata);
    assign s_out_free = !r_o_valid || o_rsp.ready;
    assign s_hit      = r_flags & r_pat;
    assign s_met      = r_all ? (s_hit == r_pat) : (s_hit != '0);
    assign s_whit     = r_flags & s_rd.pattern;
    assign s_wmet     = s_rd.need_all ? (s_whit == s_rd.pattern) : (s_whit != '0);
    assign s_idx_inc  = r_idx + 1'b1;

    always_comb begin
        case (r_func)
            FN_SET, FN_TOGGLE: s_release = s_wmet;
            FN_CANCEL:         s_release = !r_found && (s_rd.tid == r_tid);
            default:           s_release = 1'b1;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_tid        = r_tid;
        n_pat        = r_pat;
        n_all        = r_all;
        n_clr        = r_clr;
        n_flags      = r_flags;
        n_alive      = r_alive;
        n_count      = r_count;
        n_idx        = r_idx;
        n_keep       = r_keep;
        n_found      = r_found;
        n_rep_status = r_rep_status;
        n_rep_seen   = r_rep_seen;
        n_o_valid    = r_o_valid && !o_rsp.ready;
        n_o_kind     = r_o_kind;
        n_o_task     = r_o_task;
        n_o_status   = r_o_status;
        n_o_seen     = r_o_seen;
        n_o_last     = r_o_last;
        s_we         = 1'b0;
        s_waddr      = r_keep[AW-1:0];
        s_wdata      = s_rd;
        s_raddr      = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_tid   = i_req.task_id;
                    n_pat   = i_req.flag_bits;
                    n_all   = i_req.need_all;
                    n_clr   = i_req.auto_clear;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state      = S_REPLY;
                n_rep_seen   = '0;
                n_rep_status = STS_OK;
                n_idx        = '0;
                n_keep       = '0;
                n_found      = 1'b0;
                s_raddr      = '0;
                if (r_func == FN_CREATE) begin
                    if (r_alive) begin
                        n_rep_status = STS_BAD_PARAM;
                    end else begin
                        n_alive    = 1'b1;
                        n_flags    = r_pat;
                        n_count    = '0;
                        n_rep_seen = r_pat;
                    end
                end else if (!r_alive) begin
                    n_rep_status = STS_INVALID;
                end else begin
                    case (r_func)
                        FN_POLL, FN_WAIT: begin
                            if (r_pat == '0) begin
                                n_rep_status = STS_BAD_PARAM;
                            end else if (s_met) begin
                                n_rep_seen = r_flags;
                                if (r_clr) begin
                                    n_flags = r_flags & ~r_pat;
                                end
                            end else if (r_func == FN_POLL) begin
                                n_rep_status = STS_NOT_MET;
                            end else if (r_count == CW'(WAITER_SLOTS)) begin
                                n_rep_status = STS_FULL;
                            end else begin
                                s_we         = 1'b1;
                                s_waddr      = r_count[AW-1:0];
                                s_wdata      = '{tid: r_tid, pattern: r_pat,
                                                 need_all: r_all, auto_clear: r_clr};
                                n_count      = r_count + 1'b1;
                                n_rep_status = STS_QUEUED;
                            end
                        end
                        FN_CLEAR: begin
                            n_flags    = r_flags & ~r_pat;
                            n_rep_seen = r_flags & ~r_pat;
                        end
                        FN_SET: begin
                            if (s_hit != r_pat) begin
                                n_flags = r_flags | r_pat;
                                n_state = S_SCAN;
                            end else begin
                                n_rep_seen = r_flags;
                            end
                        end
                        FN_TOGGLE: begin
                            n_flags = r_flags ^ r_pat;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_state      = S_REPLY;
                    n_rep_status = STS_OK;
                    n_rep_seen   = r_flags;
                    n_count      = r_keep;
                    if (r_func == FN_DELETE) begin
                        n_count = '0;
                        n_alive = 1'b0;
                    end else if (r_func == FN_CANCEL && !r_found) begin
                        n_rep_status = STS_NOT_FOUND;
                        n_rep_seen   = '0;
                    end
                end else if (s_release) begin
                    if (s_out_free) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = 1'b1;
                        n_o_task  = s_rd.tid;
                        n_o_last  = 1'b0;
                        n_o_seen  = '0;
                        n_idx     = s_idx_inc;
                        s_raddr   = s_idx_inc[AW-1:0];
                        case (r_func)
                            FN_SET, FN_TOGGLE: begin
                                n_o_status = STS_OK;
                                n_o_seen   = r_flags;
                                if (s_rd.auto_clear) begin
                                    n_flags = r_flags & ~s_rd.pattern;
                                end
                            end
                            FN_CANCEL: begin
                                n_o_status = STS_NOT_MET;
                                n_found    = 1'b1;
                            end
                            default: begin
                                n_o_status = STS_DELETED;
                            end
                        endcase
                    end
                end else begin
                    s_we    = 1'b1;
                    s_waddr = r_keep[AW-1:0];
                    s_wdata = s_rd;
                    n_keep  = r_keep + 1'b1;
                    n_idx   = s_idx_inc;
                    s_raddr = s_idx_inc[AW-1:0];
                end
            end
            default: begin
                if (s_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = 1'b0;
                    n_o_task   = r_tid;
                    n_o_status = r_rep_status;
                    n_o_seen   = r_rep_seen;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_flags   <= '0;
            r_alive   <= 1'b1;
            r_count   <= '0;
            r_idx     <= '0;
            r_keep    <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flags   <= n_flags;
            r_alive   <= n_alive;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_keep    <= n_keep;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_tid        <= n_tid;
        r_pat        <= n_pat;
        r_all        <= n_all;
        r_clr        <= n_clr;
        r_rep_status <= n_rep_status;
        r_rep_seen   <= n_rep_seen;
        r_o_kind     <= n_o_kind;
        r_o_task     <= n_o_task;
        r_o_status   <= n_o_status;
        r_o_seen     <= n_o_seen;
        r_o_last     <= n_o_last;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.kind        = r_o_kind;
    assign o_rsp.target_task = r_o_task;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.flags_seen  = r_o_seen;
    assign o_rsp.last        = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WAITER_SLOTS))
        else $error("Waiter count exceeds the number of slots.");

    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_keep <= r_idx) && (r_idx <= r_count))
        else $error("Queue compaction overtook the scan position.");

    a_release_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind) |-> !o_rsp.last)
        else $error("A waiter release was marked as the final transaction.");

    a_dead_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_alive |-> (r_count == '0))
        else $error("A deleted group still holds waiters.");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_EXEC))
        else $error("An accepted request did not reach execution.");

endmodule
